// ===== rtl/lsfp_pkg.sv =====
// Shared types and constants for the line sensor frame parser.
// Used by lsfp_core and line_sensor_frame_parser; depends on nothing else.
package lsfp_pkg;

  // Frame geometry.
  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned MAX_FRAME   = 64;
  localparam int unsigned FRAME_LEN_W = 7;
  localparam int unsigned PAIR_W      = 4;

  // Configuration register reset values.
  localparam logic [15:0] RETRY_PERIOD_RST  = 16'd100;
  localparam logic [7:0]  TIMEOUT_TICKS_RST = 8'd20;

  // Configuration register indexes, taken from paddr[2].
  localparam logic REG_RETRY_PERIOD  = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  // Protocol characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  // Item kind.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } lsfp_op_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  sensor_mask;
    logic        mask_valid;
    logic        frame_accepted;
    logic        resend_config;
    logic [31:0] bytes_received;
    logic [31:0] frames_accepted;
  } lsfp_result_t;

endpackage

// ===== rtl/lsfp_core.sv =====
// Parser state and per-item update logic for the line sensor frame parser.
// Depends on lsfp_pkg; the result is combinational and registered by the top level.
module lsfp_core
  import lsfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  lsfp_op_t           op,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        retry_period,
  input  logic [7:0]         timeout_ticks,
  output lsfp_result_t       result
);

  // State registers.
  logic [7:0]             mask_reg,      mask_reg_next;
  logic                   valid_flag,    valid_flag_next;
  logic [7:0]             age_count,     age_count_next;
  logic [15:0]            retry_count,   retry_count_next;
  logic [FRAME_LEN_W-1:0] frame_len,     frame_len_next;
  logic                   header_ok,     header_ok_next;
  logic                   colon_pending, colon_pending_next;
  logic [PAIR_W-1:0]      pair_count,    pair_count_next;
  logic [7:0]             partial_mask,  partial_mask_next;
  logic [31:0]            byte_total,    byte_total_next;
  logic [31:0]            frame_total,   frame_total_next;
  logic                   done;
  logic                   resend;

  // Next state for one byte or one tick.
  always_comb begin
    mask_reg_next      = mask_reg;
    valid_flag_next    = valid_flag;
    age_count_next     = age_count;
    retry_count_next   = retry_count;
    frame_len_next     = frame_len;
    header_ok_next     = header_ok;
    colon_pending_next = colon_pending;
    pair_count_next    = pair_count;
    partial_mask_next  = partial_mask;
    byte_total_next    = byte_total;
    frame_total_next   = frame_total;
    done               = 1'b0;
    resend             = 1'b0;

    unique case (op)
      OP_BYTE: begin
        byte_total_next = byte_total + 32'd1;
        if (rx_byte == CH_DOLLAR) begin
          // A dollar always opens a fresh frame.
          frame_len_next     = FRAME_LEN_W'(1);
          header_ok_next     = 1'b0;
          colon_pending_next = 1'b0;
          pair_count_next    = '0;
          partial_mask_next  = '0;
        end else if (frame_len == '0) begin
          // No frame open: the byte is only counted.
        end else if (frame_len >= FRAME_LEN_W'(MAX_FRAME)) begin
          frame_len_next = '0;
        end else begin
          frame_len_next = frame_len + FRAME_LEN_W'(1);
          if (frame_len == FRAME_LEN_W'(1)) begin
            header_ok_next     = (rx_byte == CH_D);
            colon_pending_next = 1'b0;
          end else if (colon_pending && (rx_byte == CH_ZERO || rx_byte == CH_ONE)) begin
            if (rx_byte == CH_ZERO && pair_count < PAIR_W'(8)) begin
              partial_mask_next = partial_mask | (8'd1 << pair_count[2:0]);
            end
            pair_count_next    = pair_count + PAIR_W'(1);
            colon_pending_next = 1'b0;
            done = header_ok && (pair_count_next >= PAIR_W'(CHANNELS));
          end else begin
            colon_pending_next = (rx_byte == CH_COLON);
          end

          // A completed frame latches the mask; a hash closes the frame.
          if (done) begin
            mask_reg_next    = partial_mask_next;
            valid_flag_next  = 1'b1;
            age_count_next   = '0;
            frame_total_next = frame_total + 32'd1;
            frame_len_next   = '0;
          end else if (rx_byte == CH_HASH) begin
            frame_len_next = '0;
          end
        end
      end
      OP_TICK: begin
        if (!valid_flag) begin
          // No data: count toward a resend request.
          retry_count_next = retry_count + 16'd1;
          if (retry_count_next >= retry_period) begin
            retry_count_next = '0;
            resend           = 1'b1;
          end
        end else if (age_count < timeout_ticks) begin
          // Valid data ages until the timeout drops it.
          age_count_next = age_count + 8'd1;
          if (age_count_next >= timeout_ticks) begin
            valid_flag_next  = 1'b0;
            mask_reg_next    = '0;
            retry_count_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result reflects the state after this item.
  always_comb begin
    result.sensor_mask     = mask_reg_next;
    result.mask_valid      = valid_flag_next;
    result.frame_accepted  = done;
    result.resend_config   = resend;
    result.bytes_received  = byte_total_next;
    result.frames_accepted = frame_total_next;
  end

  // State update, one item per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_reg      <= '0;
      valid_flag    <= 1'b0;
      age_count     <= '0;
      retry_count   <= '0;
      frame_len     <= '0;
      header_ok     <= 1'b0;
      colon_pending <= 1'b0;
      pair_count    <= '0;
      partial_mask  <= '0;
      byte_total    <= '0;
      frame_total   <= '0;
    end else if (step) begin
      mask_reg      <= mask_reg_next;
      valid_flag    <= valid_flag_next;
      age_count     <= age_count_next;
      retry_count   <= retry_count_next;
      frame_len     <= frame_len_next;
      header_ok     <= header_ok_next;
      colon_pending <= colon_pending_next;
      pair_count    <= pair_count_next;
      partial_mask  <= partial_mask_next;
      byte_total    <= byte_total_next;
      frame_total   <= frame_total_next;
    end
  end

endmodule

// ===== rtl/line_sensor_frame_parser.sv =====
// Line sensor frame parser: input register, parser core, result register, APB registers.
// Items pass the input register, then the result register; one per cycle unless stalled.
// The rate is set by the single parser update step in lsfp_core, done once per item.
// Synchronous active-high reset clears all parser state, counters and both stages,
// and loads retry_period with 100 and timeout_ticks with 20.
module line_sensor_frame_parser
  import lsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  sensor_mask,
  output logic        mask_valid,
  output logic        frame_accepted,
  output logic        resend_config,
  output logic [31:0] bytes_received,
  output logic [31:0] frames_accepted,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]  retry_period;
  logic [7:0]   timeout_ticks;
  logic         s1_valid;
  logic         s1_op;
  logic [7:0]   s1_byte;
  logic         advance;
  lsfp_result_t core_result;
  lsfp_result_t out_data;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_period  <= RETRY_PERIOD_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_RETRY_PERIOD:  retry_period  <= pwdata[15:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RETRY_PERIOD:  prdata = {16'd0, retry_period};
      REG_TIMEOUT_TICKS: prdata = {24'd0, timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // The stage-one item moves on when the result register is free or being emptied.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  // Parser core, updated as the item leaves stage one.
  lsfp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .op            (lsfp_op_t'(s1_op)),
    .rx_byte       (s1_byte),
    .retry_period  (retry_period),
    .timeout_ticks (timeout_ticks),
    .result        (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  assign sensor_mask     = out_data.sensor_mask;
  assign mask_valid      = out_data.mask_valid;
  assign frame_accepted  = out_data.frame_accepted;
  assign resend_config   = out_data.resend_config;
  assign bytes_received  = out_data.bytes_received;
  assign frames_accepted = out_data.frames_accepted;

  // A completed frame always leaves valid data behind.
  a_frame_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_accepted |-> mask_valid)
    else $error("frame accepted without valid mask");

  // A resend request only happens while there is no valid data.
  a_resend_no_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && resend_config |-> !mask_valid && !frame_accepted)
    else $error("resend requested with valid data or accepted frame");

  // Invalid data always reads as an empty mask once it times out or before any frame.
  a_invalid_mask_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mask_valid |-> sensor_mask == 8'd0)
    else $error("mask not cleared while invalid");

  // Stage one only holds off the input while it has an item it cannot pass on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
